FILE: hdl/stc_pkg.sv
// ---------------------------------------------------------------------------
// stc_pkg: sprite tile compositor types and constants
// Transfer structs for both channels, opcodes and fixed geometry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

  // Opcodes
  localparam logic [1:0] OP_LOAD_SPRITE  = 2'd0;
  localparam logic [1:0] OP_LOAD_PALETTE = 2'd1;
  localparam logic [1:0] OP_COMPOSE      = 2'd2;

  // Geometry
  localparam int SpriteBytes   = 64;  // bytes per 16x16 sprite at 2 bpp
  localparam int PaletteSize   = 4;   // entries per palette
  localparam int TileLastPixel = 63;  // offset of the final tile pixel

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  tile_x;
    logic [8:0]  tile_y;
    logic [7:0]  sprite_x;
    logic [8:0]  sprite_y;
    logic [4:0]  sprite_index;
    logic [2:0]  palette_index;
    logic        vertical_flip;
  } stc_in_t;

  typedef struct packed {
    logic [5:0] pixel_offset;
    logic       write_enable;
    logic [3:0] color;
    logic       last;
  } stc_out_t;

endpackage

`default_nettype wire

FILE: hdl/stc_ram.sv
// ---------------------------------------------------------------------------
// stc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sprite_tile_compositor.sv
// Results: a load or unused opcode gives one acknowledge for its input
//   transfer; a compose gives 64 pixels, one per cycle while the output is
//   not stalled.
// Flow: one item at a time; the input stays stalled while the item is in its
//   issue, sprite-byte read or palette read stage.
// Reset: asynchronous, active low; clears control only, RAMs are not cleared.
// ---------------------------------------------------------------------------
// sprite_tile_compositor: 2 bpp sprite into 8x8 tile with palette lookup
// Walks the 64 tile pixels, pulls each 2-bit code out of its sprite byte and
// maps it through a 4-entry palette; code or color zero is transparent.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprite_tile_compositor #(
  parameter int NUM_SPRITES  = 32,
  parameter int NUM_PALETTES = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire stc_pkg::stc_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output stc_pkg::stc_out_t     out_data_o
);

  import stc_pkg::*;

  // Index and address widths. Concatenated addresses are size cast down,
  // which is exact for every legal index.
  localparam int SIW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
  localparam int PIW = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
  localparam int SDEPTH = NUM_SPRITES * SpriteBytes;
  localparam int PDEPTH = NUM_PALETTES * PaletteSize;
  localparam int SAW = $clog2(SDEPTH);
  localparam int PAW = $clog2(PDEPTH);

  // ---------------------------------------------------------------------
  // Handshakes. The whole pixel pipeline moves on adv; the output register
  // parts the two sides so a new item may enter while a result waits.
  // ---------------------------------------------------------------------
  logic in_xfer, adv;

  logic s0_busy_q, s0_busy_d;   // issue stage owns an item
  logic s0_ack_q;               // item is an acknowledge, one result
  logic [5:0] cnt_q, cnt_d;     // tile pixel counter, row*8 + col
  logic [9:0] px_q, py_q;       // sprite column/row of tile pixel 0
  logic [SIW-1:0] sidx_q;
  logic [PIW-1:0] pidx_q;
  logic flip_q;
  logic ok_q;                   // both indices in range

  logic v1_q, ack1_q, hit1_q;
  logic [1:0] sub1_q;           // pixel position within its byte
  logic [5:0] k1_q;

  logic v2_q, ack2_q, opq2_q;
  logic [5:0] k2_q;

  logic out_valid_q;
  stc_out_t out_q;

  assign in_stall_o = s0_busy_q | v1_q | v2_q;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign adv        = ~out_valid_q | ~out_stall_i;

  // ---------------------------------------------------------------------
  // Load writes go straight into the RAMs on the input transfer; nothing
  // is in flight then, so no read can collide.
  // ---------------------------------------------------------------------
  logic spr_we, pal_we;
  assign spr_we = in_xfer && (in_data_i.opcode == OP_LOAD_SPRITE)
                  && (32'(in_data_i.load_address) < SDEPTH);
  assign pal_we = in_xfer && (in_data_i.opcode == OP_LOAD_PALETTE)
                  && (32'(in_data_i.load_address) < PDEPTH);

  // ---------------------------------------------------------------------
  // Stage 0: pixel coordinates and sprite byte address
  // ---------------------------------------------------------------------
  logic [10:0] sr, sc;
  logic        in_sprite;
  logic [3:0]  row;
  logic [SAW-1:0] spr_raddr;

  always_comb begin
    // two's complement offsets; inside the sprite when bits above 3 are 0
    sr        = {py_q[9], py_q} + {8'b0, cnt_q[5:3]};
    sc        = {px_q[9], px_q} + {8'b0, cnt_q[2:0]};
    in_sprite = (sr[10:4] == 7'b0) && (sc[10:4] == 7'b0);
    row       = flip_q ? ~sr[3:0] : sr[3:0];
    spr_raddr = SAW'({sidx_q, row, sc[3:2]});
  end

  always_comb begin
    s0_busy_d = s0_busy_q;
    cnt_d     = cnt_q;
    if (in_xfer) begin
      s0_busy_d = 1'b1;
      cnt_d     = '0;
    end else if (s0_busy_q && adv) begin
      cnt_d = cnt_q + 6'd1;
      if (s0_ack_q || cnt_q == 6'(TileLastPixel)) begin
        s0_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_busy_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      s0_busy_q <= s0_busy_d;
      cnt_q     <= cnt_d;
    end
  end

  // item fields held for the duration of the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s0_ack_q <= in_data_i.opcode != OP_COMPOSE;
      px_q     <= {2'b0, in_data_i.tile_x} - {2'b0, in_data_i.sprite_x} + 10'd4;
      py_q     <= {1'b0, in_data_i.tile_y} - {1'b0, in_data_i.sprite_y} + 10'd4;
      sidx_q   <= SIW'(in_data_i.sprite_index);
      pidx_q   <= PIW'(in_data_i.palette_index);
      flip_q   <= in_data_i.vertical_flip;
      ok_q     <= (32'(in_data_i.sprite_index) < NUM_SPRITES)
                  && (32'(in_data_i.palette_index) < NUM_PALETTES);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: sprite byte back from RAM, pick the 2-bit code digit
  // ---------------------------------------------------------------------
  logic [7:0] spr_rdata;
  logic [1:0] code;
  logic [PAW-1:0] pal_raddr;
  logic [3:0] pal_rdata;

  stc_ram #(
    .WIDTH (8),
    .DEPTH (SDEPTH),
    .AW    (SAW)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (spr_we),
    .waddr_i (SAW'(in_data_i.load_address)),
    .wdata_i (in_data_i.load_data),
    .re_i    (adv),
    .raddr_i (spr_raddr),
    .rdata_o (spr_rdata)
  );

  always_comb begin
    case (sub1_q)
      2'd0:    code = spr_rdata[1:0];
      2'd1:    code = spr_rdata[3:2];
      2'd2:    code = spr_rdata[5:4];
      default: code = spr_rdata[7:6];
    endcase
    pal_raddr = PAW'({pidx_q, code});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s0_busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ack1_q <= s0_ack_q;
      hit1_q <= ok_q & in_sprite;
      sub1_q <= sc[1:0];
      k1_q   <= cnt_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: palette color back from RAM
  // ---------------------------------------------------------------------
  stc_ram #(
    .WIDTH (4),
    .DEPTH (PDEPTH),
    .AW    (PAW)
  ) u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (PAW'(in_data_i.load_address)),
    .wdata_i (in_data_i.load_data[3:0]),
    .re_i    (adv),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ack2_q <= ack1_q;
      opq2_q <= hit1_q & (code != 2'd0);
      k2_q   <= k1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  stc_out_t out_d;

  always_comb begin
    out_d.write_enable = ~ack2_q & opq2_q & (pal_rdata != 4'd0);
    out_d.color        = out_d.write_enable ? pal_rdata : 4'd0;
    out_d.pixel_offset = ack2_q ? 6'd0 : k2_q;
    out_d.last         = ack2_q | (k2_q == 6'(TileLastPixel));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_we_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable |-> out_data_o.color != 4'd0)
    else $error("write enable with transparent color");

  a_skip_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |-> out_data_o.color == 4'd0)
    else $error("color set on a skipped pixel");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not held off after a transfer");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.pixel_offset == 6'd0 || out_data_o.pixel_offset == 6'd63)
    else $error("last on an unexpected offset");

endmodule

`default_nettype wire

FILE: tb/stc_tile_checker.sv
// ---------------------------------------------------------------------------
// stc_tile_checker: pixel predictor and compare for the tile compositor
// Watches both channels. Every input transfer queues one expected acknowledge,
// after any load write to a private copy of the sprite and palette memories,
// or renders 64 expected tile pixels; every output transfer is compared to the oldest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_tile_checker #(
  parameter int NUM_SPRITES  = 32,
  parameter int NUM_PALETTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  stc_pkg::stc_in_t in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  stc_pkg::stc_out_t out_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import stc_pkg::*;

  logic [7:0] sprite_bytes [NUM_SPRITES*SpriteBytes];
  logic [3:0] palette_colors [NUM_PALETTES*PaletteSize];
  stc_out_t   expected_pixels [$];

  initial begin
    foreach (sprite_bytes[i]) sprite_bytes[i] = '0;
    foreach (palette_colors[i]) palette_colors[i] = '0;
  end

  task automatic report_mismatch(input string what, input stc_out_t got,
                                 input stc_out_t want);
    $display({"%0t mismatch (%s): got off %0d we %0b color %0d last %0b,",
              " expected off %0d we %0b color %0d last %0b"},
             $time, what, got.pixel_offset, got.write_enable, got.color, got.last,
             want.pixel_offset, want.write_enable, want.color, want.last);
    fail_count_o++;
  endtask

  // Applies one accepted item: any load write plus acknowledge, or 64 pixels.
  task automatic render_item(input stc_in_t item);
    stc_out_t pix;
    int       tx, ty, sx, sy, px, py, sr, sc, row, sidx, pidx, addr;
    logic [1:0] code;
    logic [3:0] shade;
    bit       drawable;
    pix = '0;
    pix.last = 1'b1;
    case (item.opcode)
      OP_LOAD_SPRITE: begin
        if (item.load_address < NUM_SPRITES*SpriteBytes)
          sprite_bytes[item.load_address] = item.load_data;
        expected_pixels.push_back(pix);
      end
      OP_LOAD_PALETTE: begin
        if (item.load_address < NUM_PALETTES*PaletteSize)
          palette_colors[item.load_address] = item.load_data[3:0];
        expected_pixels.push_back(pix);
      end
      OP_COMPOSE: begin
        tx = item.tile_x;
        ty = item.tile_y;
        sx = item.sprite_x;
        sy = item.sprite_y;
        sidx = item.sprite_index;
        pidx = item.palette_index;
        drawable = (sidx < NUM_SPRITES) && (pidx < NUM_PALETTES);
        px = tx - (sx - 4);
        py = ty - (sy - 4);
        for (int k = 0; k <= TileLastPixel; k++) begin
          pix = '0;
          pix.pixel_offset = 6'(k);
          pix.last = (k == TileLastPixel);
          sr = py + k / 8;
          sc = px + k % 8;
          if (drawable && sr >= 0 && sr < 16 && sc >= 0 && sc < 16) begin
            row  = item.vertical_flip ? 15 - sr : sr;
            addr = sidx * SpriteBytes + row * 4 + sc / 4;
            code = 2'(sprite_bytes[addr] >> (2 * (sc % 4)));
            if (code != 2'd0) begin
              shade = palette_colors[pidx * PaletteSize + code];
              if (shade != 4'd0) begin
                pix.write_enable = 1'b1;
                pix.color = shade;
              end
            end
          end
          expected_pixels.push_back(pix);
        end
      end
      default: expected_pixels.push_back(pix);
    endcase
  endtask

  always @(posedge clk_i) begin
    stc_out_t want;
    string    diff;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("transfer with nothing expected", out_data_i, '0);
        end else begin
          want = expected_pixels.pop_front();
          diff = "";
          if (out_data_i.pixel_offset !== want.pixel_offset) diff = {diff, " pixel_offset"};
          if (out_data_i.write_enable !== want.write_enable) diff = {diff, " write_enable"};
          if (out_data_i.color !== want.color) diff = {diff, " color"};
          if (out_data_i.last !== want.last) diff = {diff, " last"};
          if (diff != "") report_mismatch({"field", diff}, out_data_i, want);
        end
      end
      if (in_valid_i && !in_stall_i) render_item(in_data_i);
      pending_o <= expected_pixels.size();
    end
  end

endmodule

FILE: tb/sprite_tile_compositor_test.sv
// ---------------------------------------------------------------------------
// sprite_tile_compositor_test: stimulus and verdict for the tile compositor
// Loads one sprite bitmap and all palettes, runs a directed set of edge
// cases, then random loads, composes and no-ops under random idle bursts on
// both channels. A separate checker predicts and compares every transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_tile_compositor_test;
  import stc_pkg::*;

  localparam int NumSprites  = 32;
  localparam int NumPalettes = 8;
  localparam int RandomItems = 44;
  localparam int DrainCycles = 20;   // margin after the final drain

  // Opcode 3 has no package name; the block treats it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Only this bitmap is fully written, so only this one is ever drawn
  // where it overlaps the tile. Its index has every bit set.
  localparam int DrawnSprite = 31;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  stc_in_t   in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  stc_out_t  out_data;

  int        fail_count;
  int        pending;
  int        idle_pct;     // idle burst chance: per input item, per output cycle
  int        stall_left;   // cycles remaining in the current stall burst

  always #10 clk = ~clk;

  sprite_tile_compositor #(
    .NUM_SPRITES (NumSprites),
    .NUM_PALETTES(NumPalettes)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  stc_tile_checker #(
    .NUM_SPRITES (NumSprites),
    .NUM_PALETTES(NumPalettes)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver back-pressure: bursts of stalled cycles, counted down in stall_left.
  // A burst in progress always runs out, even once idle_pct drops to zero.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hard stop, far beyond the slowest legal run (every compose stalled on
  // every pixel still finishes well inside this).
  initial begin
    #20_000_000;
    $display("FAIL sprite_tile_compositor");
    $finish;
  end

  // ---- item builders ------------------------------------------------------

  // Fully random payload; unused fields of the items built from it start out as noise.
  function automatic stc_in_t random_fields();
    return stc_in_t'({$urandom(), $urandom()});
  endfunction

  function automatic stc_in_t sprite_byte_load(input int addr, input int data);
    stc_in_t item;
    item = random_fields();
    item.opcode       = OP_LOAD_SPRITE;
    item.load_address = 11'(addr);
    item.load_data    = 8'(data);
    return item;
  endfunction

  function automatic stc_in_t palette_load(input int idx, input int data);
    stc_in_t item;
    item = random_fields();
    item.opcode       = OP_LOAD_PALETTE;
    item.load_address = 11'(idx);
    item.load_data    = 8'(data);
    return item;
  endfunction

  function automatic stc_in_t tile_compose(input int tx, input int ty, input int sx,
                                           input int sy, input int sidx, input int pidx,
                                           input int flip);
    stc_in_t item;
    item = random_fields();
    item.opcode        = OP_COMPOSE;
    item.tile_x        = 8'(tx);
    item.tile_y        = 9'(ty);
    item.sprite_x      = 8'(sx);
    item.sprite_y      = 9'(sy);
    item.sprite_index  = 5'(sidx);
    item.palette_index = 3'(pidx);
    item.vertical_flip = 1'(flip);
    return item;
  endfunction

  function automatic int drawn_sprite();
    return DrawnSprite;
  endfunction

  // Compose aimed so the sprite lands on or near the tile: the offset of
  // the tile inside the sprite is -8..16 on both axes where the position fits.
  function automatic stc_in_t aimed_compose();
    int tx, ty, sx, sy, px, py;
    tx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31) * 8;
    ty = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 39) * 8;
    px = $urandom_range(0, 24);
    px = px - 8;
    py = $urandom_range(0, 24);
    py = py - 8;
    sx = tx + 4 - px;
    sy = ty + 4 - py;
    if (sx < 0 || sx > 255) sx = $urandom_range(0, 255);
    if (sy < 0 || sy > 511) sy = $urandom_range(0, 511);
    return tile_compose(tx, ty, sx, sy, drawn_sprite(), $urandom_range(0, 7),
                        $urandom_range(0, 1));
  endfunction

  // Compose of any bitmap, placed so far off in x that no sprite pixel is drawn.
  function automatic stc_in_t blind_compose();
    int tx;
    tx = $urandom_range(0, 255);
    return tile_compose(tx, $urandom_range(0, 511), (tx >= 16) ? tx - 16 : tx + 20,
                        $urandom_range(0, 511), $urandom_range(0, 31),
                        $urandom_range(0, 7), $urandom_range(0, 1));
  endfunction

  // ---- channel driving ----------------------------------------------------

  // Holds the item until its transfer, then, with chance idle_pct, idles with
  // junk on the bus.
  task automatic send_item(input stc_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= random_fields();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops sending until every expected pixel has been seen. The checker's
  // count is registered, so the loop waits on the clock before its first look.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // ---- main sequence ------------------------------------------------------

  initial begin
    int      pick;
    stc_in_t item;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    idle_pct   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Memory setup: the drawn bitmap and every palette entry written, so
    // no compose below can draw from an unwritten location.
    idle_pct <= 15;
    for (int b = 0; b < SpriteBytes; b++)
      send_item(sprite_byte_load(DrawnSprite * SpriteBytes + b, $urandom_range(0, 255)));
    for (int p = 0; p < NumPalettes * PaletteSize; p++)
      send_item(palette_load(p, $urandom_range(0, 255)));

    // Directed cases.
    idle_pct <= 10;
    send_item(palette_load(NumPalettes * PaletteSize, 8'hff));   // just past the table
    send_item(palette_load(2047, 8'h5a));                        // top of the address field
    send_item(palette_load(1, 8'h00));                           // transparent color
    send_item(palette_load(2 * PaletteSize + 2, 8'hf5));         // high nibble dropped
    send_item(palette_load(7 * PaletteSize + 3, 8'h0f));
    send_item(sprite_byte_load(2047, 8'hff));                    // last byte of memory
    send_item(sprite_byte_load(DrawnSprite * SpriteBytes, 8'h1b));  // codes 3,2,1,0
    item = random_fields();
    item.opcode = OP_UNUSED;
    send_item(item);
    send_item(tile_compose(0, 0, 4, 4, DrawnSprite, 0, 0));      // tile on sprite corner
    send_item(tile_compose(0, 0, 4, 4, DrawnSprite, 0, 1));      // same, flipped
    send_item(tile_compose(8, 8, 4, 4, DrawnSprite, 2, 0));      // lower-right quadrant
    send_item(tile_compose(0, 0, 9, 10, DrawnSprite, 1, 0));     // clipped on top/left
    send_item(tile_compose(0, 0, 0, 0, DrawnSprite, 7, 1));      // corner at -4,-4
    send_item(tile_compose(255, 511, 255, 511, DrawnSprite, 7, 1));
    send_item(tile_compose(248, 312, 255, 319, DrawnSprite, 5, 0));
    send_item(tile_compose(3, 5, 10, 12, DrawnSprite, 3, 1));    // unaligned tile
    send_item(tile_compose(64, 64, 68, 68, DrawnSprite, 7, 0));
    send_item(tile_compose(0, 0, 200, 300, 17, 4, 0));           // no overlap
    send_item(tile_compose(255, 511, 0, 0, 9, 6, 1));            // no overlap, far corner
    item = '0;
    item.opcode = OP_UNUSED;
    send_item(item);

    // Sender holds off until the block has emptied out.
    drain_results();

    // Random mix; mostly composes, most of them aimed at the tile.
    for (int i = 0; i < RandomItems; i++) begin
      if (i < 12)       idle_pct <= 20;
      else if (i < 24)  idle_pct <= 0;
      else if (i < 34)  idle_pct <= 45;
      else              idle_pct <= 0;   // quiet tail
      if (i == RandomItems / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        item = aimed_compose();
      end else if (pick < 55) begin
        item = random_fields();
        item.opcode = OP_COMPOSE;
        item.sprite_index = 5'(drawn_sprite());
      end else if (pick < 62) begin
        item = blind_compose();
      end else if (pick < 80) begin
        item = sprite_byte_load(($urandom_range(0, 9) < 7)
                                ? drawn_sprite() * SpriteBytes + $urandom_range(0, 63)
                                : $urandom_range(0, 2047), $urandom_range(0, 255));
      end else if (pick < 92) begin
        item = palette_load(($urandom_range(0, 9) < 8)
                            ? $urandom_range(0, NumPalettes * PaletteSize - 1)
                            : $urandom_range(NumPalettes * PaletteSize, 2047),
                            $urandom_range(0, 255));
      end else begin
        item = random_fields();
        item.opcode = OP_UNUSED;
      end
      send_item(item);
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS sprite_tile_compositor");
    end else begin
      $display("FAIL sprite_tile_compositor");
    end
    $finish;
  end

endmodule
